/* src/sparse_product_work_histogram_macros.svh */
// ----------------------------------------------------------------------------
// sparse product work histogram assertion macros
// shared property wrappers for the histogram block
// ----------------------------------------------------------------------------
`ifndef SPARSE_PRODUCT_WORK_HISTOGRAM_MACROS_SVH
`define SPARSE_PRODUCT_WORK_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define SPWH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPWH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/spwh_pkg.sv */
// ----------------------------------------------------------------------------
// spwh_pkg
// types and constants of the sparse product work histogram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spwh_pkg;

   localparam int MAX_ROWS_DEF     = 1024;
   localparam int MAX_NONZEROS_DEF = 8192;
   localparam int NUM_BOUNDS_DEF   = 4;

   localparam int PTR_W   = 14;
   localparam int COL_W   = 10;
   localparam int LIMIT_W = 11;
   localparam int CNT_W   = 11;
   localparam int TOT_W   = 14;
   localparam int BIN_W   = 3;
   localparam int DATA_W  = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [TOT_W-1:0] TOT_MAX = '1;

   localparam logic [1:0] MODE_B_PTR   = 2'd0;
   localparam logic [1:0] MODE_A_PTR   = 2'd1;
   localparam logic [1:0] MODE_A_COL   = 2'd2;
   localparam logic [1:0] MODE_COMPUTE = 2'd3;

   localparam int REG_ROW_LIMIT = 0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PREAD0,
      ST_PSTART,
      ST_PREAD,
      ST_PEND,
      ST_CREAD,
      ST_CNT,
      ST_INC,
      ST_BIN,
      ST_EMIT
   } spwh_state_type;

endpackage

/* src/sparse_product_work_histogram.sv */
// ----------------------------------------------------------------------------
// sparse_product_work_histogram
// loads sparse row pointers and column indices, counts columns of long A rows
// and sums the counts into bins of B row length
// ----------------------------------------------------------------------------
// channel  dir  handshake                        payload
// req      in   start & !busy                    req_mode, req_ptr_value, req_col_index
// rsp      out  rsp_valid, one beat per cycle    rsp_bin_index, rsp_bin_total, rsp_last
// csr      in   psel & penable & pwrite (pready) paddr, pwdata, prdata
//
// load beats (modes 0..2) never raise busy
// compute: clear the counter memory, read the first A pointer when A has rows,
// then per A row read its end pointer and, when the row reaches the row limit,
// walk its columns and count each visited nonzero inside B, then scan the
// B lengths into the bins, then NUM_BOUNDS + 1 result beats
// synchronous reset clears control state and the row limit and sets each bound to its index; memories are not reset
// results cannot be stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_product_work_histogram import spwh_pkg::*; #(
   parameter int MAX_ROWS     = MAX_ROWS_DEF,
   parameter int MAX_NONZEROS = MAX_NONZEROS_DEF,
   parameter int NUM_BOUNDS   = NUM_BOUNDS_DEF,
   localparam int ADDR_W      = $clog2(NUM_BOUNDS + 1) + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [PTR_W-1:0]   req_ptr_value,
   input  logic [COL_W-1:0]   req_col_index,
   output logic               rsp_valid,
   output logic [BIN_W-1:0]   rsp_bin_index,
   output logic [TOT_W-1:0]   rsp_bin_total,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

`include "sparse_product_work_histogram_macros.svh"

   localparam int RAW = $clog2(MAX_ROWS);
   localparam int RCW = $clog2(MAX_ROWS + 2);
   localparam int PAW = $clog2(MAX_ROWS + 1);
   localparam int NAW = $clog2(MAX_NONZEROS);
   localparam int NCW = $clog2(MAX_NONZEROS + 1);
   localparam int IW  = ADDR_W - 2;

   logic [PTR_W-1:0]   b_len_mem [MAX_ROWS];
   logic [PTR_W-1:0]   a_ptr_mem [MAX_ROWS+1];
   logic [COL_W-1:0]   a_col_mem [MAX_NONZEROS];
   logic [CNT_W-1:0]   cnt_mem   [MAX_ROWS];

   logic [PTR_W-1:0]   b_len_q, a_ptr_q;
   logic [COL_W-1:0]   a_col_q;
   logic [CNT_W-1:0]   cnt_q;

   spwh_state_type     state_ff, state_in;
   logic [LIMIT_W-1:0] row_limit_ff;
   logic [PTR_W-1:0]   bound_ff [NUM_BOUNDS];
   logic [RCW-1:0]     b_seen_ff, a_seen_ff;
   logic [PTR_W-1:0]   prev_b_ff;
   logic [NCW-1:0]     col_seen_ff;
   logic [RCW-1:0]     row_ff, row_in, br_ff, br_in;
   logic [PTR_W-1:0]   start_ff, start_in, end_ff, end_in, j_ff, j_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               bv_ff, bv_in;
   logic [BIN_W-1:0]   k_ff, k_in;
   logic [TOT_W-1:0]   tot_ff [NUM_BOUNDS+1];
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [BIN_W-1:0]   rsp_bin_ff, rsp_bin_in;
   logic [TOT_W-1:0]   rsp_tot_ff, rsp_tot_in;

   logic               accept, cfg_wr, compute_go;
   logic [RCW-1:0]     b_rows, a_rows;
   logic               cnt_we, row_next;
   logic [RAW-1:0]     cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [PAW-1:0]     a_ptr_raddr;
   logic [IW-1:0]      reg_idx;
   logic [BIN_W-1:0]   bin_sel;
   logic [TOT_W:0]     bin_sum;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign compute_go = accept && (req_mode == MODE_COMPUTE);
   assign pready     = 1'b1;
   assign cfg_wr     = psel && penable && pwrite && pready;
   assign reg_idx    = paddr[ADDR_W-1:2];
   assign b_rows     = (b_seen_ff != '0) ? b_seen_ff - 1'b1 : '0;
   assign a_rows     = (a_seen_ff != '0) ? a_seen_ff - 1'b1 : '0;

   always_comb begin
      prdata = '0;
      if (32'(reg_idx) == REG_ROW_LIMIT) begin
         prdata = DATA_W'(row_limit_ff);
      end
      for (int k = 0; k < NUM_BOUNDS; k++) begin
         if (32'(reg_idx) == k + 1) begin
            prdata = DATA_W'(bound_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= '0;
         for (int k = 0; k < NUM_BOUNDS; k++) begin
            bound_ff[k] <= PTR_W'(k);
         end
      end else if (cfg_wr) begin
         if (32'(reg_idx) == REG_ROW_LIMIT) begin
            row_limit_ff <= pwdata[LIMIT_W-1:0];
         end
         for (int k = 0; k < NUM_BOUNDS; k++) begin
            if (32'(reg_idx) == k + 1) begin
               bound_ff[k] <= pwdata[PTR_W-1:0];
            end
         end
      end
   end

   // load counters and load writes
   always_ff @(posedge clock) begin
      if (reset) begin
         b_seen_ff   <= '0;
         a_seen_ff   <= '0;
         col_seen_ff <= '0;
         prev_b_ff   <= '0;
      end else if (accept) begin
         case (req_mode)
            MODE_B_PTR: begin
               if (32'(b_seen_ff) < MAX_ROWS + 1) begin
                  prev_b_ff <= req_ptr_value;
                  b_seen_ff <= b_seen_ff + 1'b1;
               end
            end
            MODE_A_PTR: begin
               if (32'(a_seen_ff) < MAX_ROWS + 1) begin
                  a_seen_ff <= a_seen_ff + 1'b1;
               end
            end
            MODE_A_COL: begin
               if (32'(col_seen_ff) < MAX_NONZEROS) begin
                  col_seen_ff <= col_seen_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_B_PTR && b_seen_ff != '0
          && 32'(b_seen_ff) < MAX_ROWS + 1) begin
         b_len_mem[RAW'(b_seen_ff - 1'b1)] <=
            (req_ptr_value >= prev_b_ff) ? req_ptr_value - prev_b_ff : '0;
      end
      b_len_q <= b_len_mem[br_ff[RAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_A_PTR && 32'(a_seen_ff) < MAX_ROWS + 1) begin
         a_ptr_mem[a_seen_ff[PAW-1:0]] <= req_ptr_value;
      end
      a_ptr_q <= a_ptr_mem[a_ptr_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_A_COL && 32'(col_seen_ff) < MAX_NONZEROS) begin
         a_col_mem[col_seen_ff[NAW-1:0]] <= req_col_index;
      end
      a_col_q <= a_col_mem[NAW'(j_ff)];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= cnt_mem[cnt_raddr];
   end

   // first bin whose bound is at or above the length
   always_comb begin
      bin_sel = BIN_W'(NUM_BOUNDS);
      for (int k = NUM_BOUNDS - 1; k >= 0; k--) begin
         if (b_len_q <= bound_ff[k]) begin
            bin_sel = BIN_W'(k);
         end
      end
      bin_sum = {1'b0, tot_ff[bin_sel]} + (TOT_W+1)'(cnt_q);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      br_in        = br_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      j_in         = j_ff;
      col_in       = col_ff;
      bv_in        = 1'b0;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_bin_in   = k_ff;
      rsp_tot_in   = tot_ff[k_ff];
      rsp_last_in  = (32'(k_ff) == NUM_BOUNDS);
      cnt_we       = 1'b0;
      cnt_waddr    = br_ff[RAW-1:0];
      cnt_wdata    = '0;
      cnt_raddr    = br_ff[RAW-1:0];
      a_ptr_raddr  = '0;
      row_next     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (compute_go) begin
               state_in = ST_CLEAR;
               br_in    = '0;
            end
         end
         ST_CLEAR: begin
            cnt_we = 1'b1;
            br_in  = br_ff + 1'b1;
            if (32'(br_ff) == MAX_ROWS - 1) begin
               br_in    = '0;
               row_in   = '0;
               state_in = (a_rows != '0) ? ST_PREAD0 : ST_BIN;
            end
         end
         ST_PREAD0: begin
            state_in = ST_PSTART;
         end
         ST_PSTART: begin
            start_in = a_ptr_q;
            state_in = ST_PREAD;
         end
         ST_PREAD: begin
            a_ptr_raddr = PAW'(row_ff + 1'b1);
            state_in    = ST_PEND;
         end
         ST_PEND: begin
            end_in = a_ptr_q;
            j_in   = start_ff;
            if (a_ptr_q >= start_ff
                && (a_ptr_q - start_ff) >= PTR_W'(row_limit_ff)) begin
               state_in = ST_CREAD;
            end else begin
               row_next = 1'b1;
            end
         end
         ST_CREAD: begin
            if (j_ff < end_ff && 32'(j_ff) < 32'(col_seen_ff)) begin
               state_in = ST_CNT;
            end else begin
               row_next = 1'b1;
            end
         end
         ST_CNT: begin
            cnt_raddr = RAW'(a_col_q);
            col_in    = a_col_q;
            j_in      = j_ff + 1'b1;
            state_in  = (32'(a_col_q) < 32'(b_rows)) ? ST_INC : ST_CREAD;
         end
         ST_INC: begin
            cnt_waddr = RAW'(col_ff);
            cnt_wdata = cnt_q + 1'b1;
            cnt_we    = (cnt_q != CNT_MAX);
            state_in  = ST_CREAD;
         end
         ST_BIN: begin
            if (br_ff < b_rows) begin
               bv_in     = 1'b1;
               br_in     = br_ff + 1'b1;
            end else if (!bv_ff) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            k_in         = k_ff + 1'b1;
            if (32'(k_ff) == NUM_BOUNDS) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (row_next) begin
         start_in = end_in;
         row_in   = row_ff + 1'b1;
         br_in    = '0;
         state_in = (row_ff + 1'b1 >= a_rows) ? ST_BIN : ST_PREAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         row_ff       <= '0;
         br_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         bv_ff        <= bv_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         row_ff       <= row_in;
         br_ff        <= br_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      j_ff        <= j_in;
      col_ff      <= col_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_last_ff <= rsp_last_in;
      if (compute_go) begin
         for (int k = 0; k <= NUM_BOUNDS; k++) begin
            tot_ff[k] <= '0;
         end
      end else if (bv_ff) begin
         tot_ff[bin_sel] <= bin_sum[TOT_W] ? TOT_MAX : bin_sum[TOT_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_bin_total = rsp_tot_ff;
   assign rsp_last      = rsp_valid_ff && rsp_last_ff;

   `SPWH_ASSERT_NEXT(a_compute_busy, clock, reset, compute_go, busy,
      "compute beat did not raise busy")
   `SPWH_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid,
      "result beat after the last bin")
   `SPWH_ASSERT_NEXT(a_bin_order, clock, reset, rsp_valid && !rsp_last,
      rsp_valid && rsp_bin_index == $past(rsp_bin_index) + 1'b1,
      "bins not emitted in order")
   `SPWH_ASSERT_NOW(a_inc_in_range, clock, reset, state_ff == ST_INC,
      32'(col_ff) < 32'(b_rows), "counter update outside B rows")
   `SPWH_ASSERT_NOW(a_bin_idle_counts, clock, reset, bv_ff,
      state_ff == ST_BIN, "bin accumulate outside the bin scan")

endmodule
